[rtl/stq_pkg.sv]
// Shared types and constants of the sorted task timer queue.
// Holds the entry and command structs that pass between the controller and the cells.
// No dependencies.
package stq_pkg;

   // default queue depth
   localparam int MAX_TASKS_DEFAULT = 16;

   // field widths fixed by the word layout
   localparam int HANDLE_W = 8;
   localparam int TIME_W   = 16;
   localparam int INDEX_W  = 4;
   localparam int POS_W    = 5;

   // at most this many dispatched tasks are reported by one dispatch
   localparam logic [4:0] OUT_LIMIT = 5'd16;

   // saturation value of the tick and due counters
   localparam logic [TIME_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      ACT_TICK,
      ACT_ADD,
      ACT_DELETE,
      ACT_DISPATCH
   } action_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_FULL,
      ST_BAD_INDEX
   } status_type;

   // operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_TICK,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_MARK,
      CELL_CATCHUP
   } cell_op_type;

   // one timer entry as held in a cell
   typedef struct packed {
      logic                valid;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   delay;
      logic [TIME_W-1:0]   period;
      logic [TIME_W-1:0]   due;
      logic                mark;
   } stq_entry_type;

   // command bus from the controller to the cells
   typedef struct packed {
      cell_op_type         op;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   delay;
      logic [TIME_W-1:0]   period;
      logic [INDEX_W-1:0]  index;
      logic [TIME_W-1:0]   head_delay;
      logic [TIME_W-1:0]   elapsed;
   } stq_cmd_type;

endpackage

[rtl/stq_cell.sv]
// One cell of the sorted timer chain: holds a single entry and trades it with its neighbours.
// Depends on stq_pkg for the entry and command structs.
module stq_cell
   import stq_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  stq_cmd_type   cmd,
   input  stq_entry_type left_entry,
   input  logic          left_after,
   input  stq_entry_type right_entry,
   output stq_entry_type entry,
   output logic          after,
   output logic          take_new
);

   stq_entry_type entry_ff;
   stq_entry_type entry_in;
   logic [TIME_W-1:0] tick_delay;

   // a new word with this delay belongs behind this cell's entry
   assign after    = entry_ff.valid && (cmd.delay >= entry_ff.delay);
   assign take_new = left_after && !after;
   assign entry    = entry_ff;

   assign tick_delay = (entry_ff.delay != '0) ? entry_ff.delay - 1'b1 : '0;

   // next entry for each chain operation
   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_TICK: begin
            if (CELL_INDEX == 0 && entry_ff.valid) begin
               entry_in.delay = tick_delay;
               if (tick_delay == '0 && entry_ff.due != COUNT_MAX) begin
                  entry_in.due = entry_ff.due + 1'b1;
               end
            end
         end
         CELL_INSERT: begin
            if (!left_after) begin
               // shift one place towards the tail
               entry_in = left_entry;
            end else if (!after) begin
               entry_in.valid  = 1'b1;
               entry_in.handle = cmd.handle;
               entry_in.delay  = cmd.delay;
               entry_in.period = cmd.period;
               entry_in.due    = '0;
            end
         end
         CELL_REMOVE: begin
            // close the gap from the tail side
            if (CELL_INDEX >= int'(cmd.index)) begin
               entry_in = right_entry;
            end
         end
         CELL_MARK: begin
            entry_in.mark = (entry_ff.delay == cmd.head_delay);
         end
         CELL_CATCHUP: begin
            if (entry_ff.valid) begin
               if (entry_ff.mark) begin
                  entry_in.delay = '0;
                  entry_in.due   = TIME_W'(1);
               end else begin
                  entry_in.delay = (entry_ff.delay >= cmd.elapsed) ?
                                   entry_ff.delay - cmd.elapsed : '0;
               end
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.handle <= entry_in.handle;
      entry_ff.delay  <= entry_in.delay;
      entry_ff.period <= entry_in.period;
      entry_ff.due    <= entry_in.due;
      entry_ff.mark   <= entry_in.mark;
   end

endmodule

[rtl/sorted_task_timer_queue.sv]
// Sorted timer task queue of up to MAX_TASKS entries kept in ascending order of delay, held in a
// row of cells that insert, remove and catch up in parallel under one sequencer. One word is
// handled at a time: a tick and a failed add or delete pass through execute and reply, a good add
// or delete through execute, re-mark and reply, a dispatch with nothing due through execute and
// reply, and one that runs tasks through execute, catch-up, then per task pop, reinsert (periodic
// only), re-mark and reply; a reply waits while an earlier one is held and rsp_tready is low. The
// chain does one operation per cycle and there is a single reply register. The request ready is
// high only while the sequencer is idle. Depends on stq_pkg and stq_cell.
module sorted_task_timer_queue
   import stq_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // task_handle[7:0], delay[23:8], period[39:24],
                                   // del_index[43:40], zero fill
   input  logic [1:0]  req_tuser,  // action
   // reply words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // status[1:0], position[6:2], run_handle[14:7],
                                   // occupancy[19:15], zero fill
   output logic        rsp_tuser,  // ran
   output logic        rsp_tlast
);

   localparam int IdxW   = $clog2(MAX_TASKS);
   localparam int CountW = $clog2(MAX_TASKS + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_MARK,
      S_REPLY,
      S_CATCHUP,
      S_POP,
      S_REINSERT,
      S_NEXT,
      S_RUN_REPLY
   } state_type;

   state_type            state_ff;
   action_type           act_ff;
   logic [HANDLE_W-1:0]  handle_ff;
   logic [TIME_W-1:0]    delay_ff;
   logic [TIME_W-1:0]    period_ff;
   logic [INDEX_W-1:0]   index_ff;
   logic [CountW-1:0]    total_ff;
   logic [TIME_W-1:0]    elapsed_ff;
   status_type           status_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [MAX_TASKS-1:0] insert_hot_ff;
   logic [HANDLE_W-1:0]  run_handle_ff;
   logic [TIME_W-1:0]    run_period_ff;
   logic [4:0]           run_count_ff;
   logic                 rsp_tvalid_ff;
   logic [23:0]          rsp_tdata_ff;
   logic                 rsp_tuser_ff;
   logic                 rsp_tlast_ff;

   stq_cmd_type          cmd;
   stq_entry_type        chain_entry [MAX_TASKS];
   logic [MAX_TASKS-1:0] chain_after;
   logic [MAX_TASKS-1:0] chain_take;
   logic [MAX_TASKS-1:0] valid_vec;
   logic                 table_full;
   logic                 bad_index;
   logic                 head_due;
   logic                 run_more;
   logic                 slot_free;
   logic                 reply_load;
   logic [IdxW-1:0]      pos_enc;
   logic                 sorted_ok;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   assign table_full = (int'(total_ff) >= MAX_TASKS);
   assign bad_index  = (int'(index_ff) >= int'(total_ff));
   assign head_due   = chain_entry[0].valid && (chain_entry[0].due != '0);
   assign run_more   = head_due && (run_count_ff != OUT_LIMIT);
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign reply_load = slot_free && (state_ff == S_REPLY || state_ff == S_RUN_REPLY);

   // command broadcast to the chain
   always_comb begin
      cmd.op         = CELL_HOLD;
      cmd.handle     = handle_ff;
      cmd.delay      = delay_ff;
      cmd.period     = period_ff;
      cmd.index      = index_ff;
      cmd.head_delay = chain_entry[0].delay;
      cmd.elapsed    = elapsed_ff;
      case (state_ff)
         S_EXEC: begin
            case (act_ff)
               ACT_TICK:   cmd.op = CELL_TICK;
               ACT_ADD:    cmd.op = table_full ? CELL_HOLD : CELL_INSERT;
               ACT_DELETE: cmd.op = bad_index ? CELL_HOLD : CELL_REMOVE;
               default:    cmd.op = CELL_HOLD;
            endcase
         end
         S_MARK, S_NEXT: cmd.op = CELL_MARK;
         S_CATCHUP:      cmd.op = CELL_CATCHUP;
         S_POP: begin
            cmd.op    = CELL_REMOVE;
            cmd.index = '0;
         end
         S_REINSERT: begin
            cmd.op     = CELL_INSERT;
            cmd.handle = run_handle_ff;
            cmd.delay  = run_period_ff;
            cmd.period = run_period_ff;
         end
         default: cmd.op = CELL_HOLD;
      endcase
   end

   // the chain of cells, head at index 0
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      stq_entry_type left_entry;
      stq_entry_type right_entry;
      logic          left_after;

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_after = 1'b1;
      end else begin : g_body
         assign left_entry = chain_entry[i-1];
         assign left_after = chain_after[i-1];
      end

      if (i == MAX_TASKS - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = chain_entry[i+1];
      end

      stq_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_after  (left_after),
         .right_entry (right_entry),
         .entry       (chain_entry[i]),
         .after       (chain_after[i]),
         .take_new    (chain_take[i])
      );

      assign valid_vec[i] = chain_entry[i].valid;
   end

   // binary position of the cell that took the new entry
   always_comb begin
      pos_enc = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (insert_hot_ff[i]) begin
            pos_enc = pos_enc | IdxW'(i);
         end
      end
   end

   // ascending order check over neighbouring cells
   always_comb begin
      sorted_ok = 1'b1;
      for (int i = 1; i < MAX_TASKS; i++) begin
         if (chain_entry[i].valid &&
             (!chain_entry[i-1].valid || chain_entry[i].delay < chain_entry[i-1].delay)) begin
            sorted_ok = 1'b0;
         end
      end
   end

   // sequencer, counters and reply register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         total_ff      <= '0;
         elapsed_ff    <= '0;
         run_count_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // reply valid: set when a reply state loads, dropped once taken
         if (reply_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  act_ff    <= action_type'(req_tuser);
                  handle_ff <= req_tdata[7:0];
                  delay_ff  <= req_tdata[23:8];
                  period_ff <= req_tdata[39:24];
                  index_ff  <= req_tdata[43:40];
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               status_ff     <= (act_ff == ACT_ADD && table_full) ? ST_FULL :
                                (act_ff == ACT_DELETE && bad_index) ? ST_BAD_INDEX : ST_OK;
               pos_ff        <= (act_ff == ACT_ADD && table_full) ? POS_W'(MAX_TASKS) : '0;
               insert_hot_ff <= chain_take;
               unique case (act_ff)
                  ACT_TICK: begin
                     if (total_ff != '0 && elapsed_ff != COUNT_MAX) begin
                        elapsed_ff <= elapsed_ff + 1'b1;
                     end
                     state_ff <= S_REPLY;
                  end
                  ACT_ADD: begin
                     if (table_full) begin
                        state_ff  <= S_REPLY;
                     end else begin
                        if (total_ff == '0) begin
                           elapsed_ff <= '0;
                        end
                        total_ff <= total_ff + 1'b1;
                        state_ff <= S_MARK;
                     end
                  end
                  ACT_DELETE: begin
                     if (bad_index) begin
                        state_ff  <= S_REPLY;
                     end else begin
                        total_ff <= total_ff - 1'b1;
                        state_ff <= S_MARK;
                     end
                  end
                  ACT_DISPATCH: begin
                     run_count_ff <= '0;
                     state_ff     <= head_due ? S_CATCHUP : S_REPLY;
                  end
                  default: state_ff <= S_REPLY;
               endcase
            end
            S_MARK: begin
               if (act_ff == ACT_ADD) begin
                  pos_ff <= POS_W'(pos_enc);
               end
               state_ff <= S_REPLY;
            end
            S_REPLY: begin
               if (slot_free) begin
                  rsp_tdata_ff  <= {4'b0, POS_W'(total_ff), {HANDLE_W{1'b0}}, pos_ff,
                                    status_ff};
                  rsp_tuser_ff  <= 1'b0;
                  rsp_tlast_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_CATCHUP: begin
               state_ff <= S_POP;
            end
            S_POP: begin
               run_handle_ff <= chain_entry[0].handle;
               run_period_ff <= chain_entry[0].period;
               total_ff      <= total_ff - 1'b1;
               state_ff      <= (chain_entry[0].period != '0) ? S_REINSERT : S_NEXT;
            end
            S_REINSERT: begin
               total_ff <= total_ff + 1'b1;
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               run_count_ff <= run_count_ff + 1'b1;
               state_ff     <= S_RUN_REPLY;
            end
            S_RUN_REPLY: begin
               if (slot_free) begin
                  rsp_tdata_ff  <= {4'b0, POS_W'(total_ff), run_handle_ff, {POS_W{1'b0}},
                                    ST_OK};
                  rsp_tuser_ff  <= 1'b1;
                  rsp_tlast_ff  <= !run_more;
                  if (run_more) begin
                     state_ff <= S_POP;
                  end else begin
                     elapsed_ff <= '0;
                     state_ff   <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // the number of occupied cells always equals the task count
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(total_ff))
      else $error("occupied cells disagree with task count");

   // the queue is in ascending order of delay whenever a word may be taken
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> sorted_ok)
      else $error("queue out of order");

   // after re-marking, a present head always shares its own delay
   a_head_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK || state_ff == S_NEXT) |=> (!chain_entry[0].valid || chain_entry[0].mark))
      else $error("head entry not marked");

   // a dispatch never reports more than the limit of tasks
   a_run_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN_REPLY |-> (run_count_ff != '0 && run_count_ff <= OUT_LIMIT))
      else $error("dispatch run count out of range");

endmodule

[verif/tb_sorted_task_timer_queue.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the sorted task timer queue: directed and random tests.
// Predicts every reply word from its own copy of the timer table and checks each one in order.
// Depends on stq_pkg and sorted_task_timer_queue.
module tb_sorted_task_timer_queue;
   import stq_pkg::*;

   localparam int DEPTH       = MAX_TASKS_DEFAULT;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 20;

   typedef struct packed {
      status_type  status;
      logic [4:0]  position;
      logic [7:0]  run_handle;
      logic        ran;
      logic        last;
      logic [4:0]  occupancy;
   } reply_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = ACT_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // predicted timer table
   logic [7:0]  slot_handle [DEPTH];
   logic [15:0] slot_delay  [DEPTH];
   logic [15:0] slot_period [DEPTH];
   logic [15:0] slot_due    [DEPTH];
   logic        slot_joint  [DEPTH];
   int          held;
   logic [15:0] ticks_since;

   reply_word_type replies_due[$];
   reply_word_type want;
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int take_idle_pct = 0;

   sorted_task_timer_queue #(.MAX_TASKS(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= take_idle_pct);
   end

   // ---------------------------------------------------------------- prediction

   function automatic void clear_slot(int i);
      slot_handle[i] = '0;
      slot_delay[i]  = '0;
      slot_period[i] = '0;
      slot_due[i]    = '0;
      slot_joint[i]  = 1'b0;
   endfunction

   // the share-head flag is not moved with an entry; it is rebuilt afterwards
   function automatic void move_slot(int dst, int src);
      slot_handle[dst] = slot_handle[src];
      slot_delay[dst]  = slot_delay[src];
      slot_period[dst] = slot_period[src];
      slot_due[dst]    = slot_due[src];
   endfunction

   function automatic void mark_head_peers();
      int n;
      for (n = 0; n < held; n++) slot_joint[n] = (slot_delay[n] == slot_delay[0]);
   endfunction

   function automatic status_type insert_timer(logic [7:0] h, logic [15:0] d, logic [15:0] p,
                                               output logic [4:0] pos);
      int at;
      int i;
      at = 0;
      if (held == 0) begin
         clear_slot(0);
         slot_handle[0] = h;
         slot_delay[0]  = d;
         slot_period[0] = p;
         slot_joint[0]  = 1'b1;
         ticks_since    = '0;
         held           = 1;
         pos            = '0;
         return ST_OK;
      end
      if (held >= DEPTH) begin
         pos = 5'(DEPTH);
         return ST_FULL;
      end
      // goes behind every entry with an equal or smaller delay
      while (at < held && d >= slot_delay[at]) at++;
      for (i = held; i > at; i--) move_slot(i, i - 1);
      slot_handle[at] = h;
      slot_delay[at]  = d;
      slot_period[at] = p;
      slot_due[at]    = '0;
      held++;
      mark_head_peers();
      pos = 5'(at);
      return ST_OK;
   endfunction

   function automatic status_type remove_timer(int idx);
      int k;
      if (held == 0 || idx >= held) return ST_BAD_INDEX;
      for (k = idx; k + 1 < held; k++) move_slot(k, k + 1);
      clear_slot(held - 1);
      held--;
      mark_head_peers();
      return ST_OK;
   endfunction

   function automatic reply_word_type make_reply(status_type st, logic [4:0] pos,
                                                 logic [7:0] h, logic ran, logic last);
      reply_word_type w;
      w.status     = st;
      w.position   = pos;
      w.run_handle = h;
      w.ran        = ran;
      w.last       = last;
      w.occupancy  = 5'(held);
      return w;
   endfunction

   // works out the reply words of one accepted request word
   task automatic predict_replies(action_type act, logic [7:0] h, logic [15:0] d,
                                  logic [15:0] p, logic [3:0] idx);
      status_type     st;
      logic [4:0]     pos;
      logic [4:0]     spare_pos;
      logic [7:0]     run_h;
      logic [15:0]    run_p;
      reply_word_type runs [DEPTH];
      int             run_count;
      int             m;
      run_count = 0;
      case (act)
         ACT_TICK: begin
            if (held > 0) begin
               if (slot_delay[0] != '0) slot_delay[0]--;
               if (ticks_since != COUNT_MAX) ticks_since++;
               if (slot_delay[0] == '0 && slot_due[0] != COUNT_MAX) slot_due[0]++;
            end
            replies_due.push_back(make_reply(ST_OK, '0, '0, 1'b0, 1'b1));
         end
         ACT_ADD: begin
            st = insert_timer(h, d, p, pos);
            replies_due.push_back(make_reply(st, pos, '0, 1'b0, 1'b1));
         end
         ACT_DELETE: begin
            st = remove_timer(int'(idx));
            replies_due.push_back(make_reply(st, '0, '0, 1'b0, 1'b1));
         end
         default: begin
            if (held > 0 && slot_due[0] != '0) begin
               // catch up the delays; entries sharing the head's delay fall due with it
               for (m = 0; m < held; m++) begin
                  if (!slot_joint[m]) begin
                     slot_delay[m] = (slot_delay[m] >= ticks_since) ?
                                     slot_delay[m] - ticks_since : '0;
                  end else begin
                     slot_delay[m] = '0;
                     slot_due[m]   = 16'd1;
                  end
               end
               while (held > 0 && slot_due[0] != '0 && run_count < int'(OUT_LIMIT)) begin
                  run_h = slot_handle[0];
                  run_p = slot_period[0];
                  slot_due[0]--;
                  void'(remove_timer(0));
                  if (run_p != '0) void'(insert_timer(run_h, run_p, run_p, spare_pos));
                  runs[run_count] = make_reply(ST_OK, '0, run_h, 1'b1, 1'b0);
                  run_count++;
               end
               ticks_since = '0;
            end
            if (run_count == 0) begin
               replies_due.push_back(make_reply(ST_OK, '0, '0, 1'b0, 1'b1));
            end else begin
               for (m = 0; m < run_count; m++) begin
                  runs[m].last = (m == run_count - 1);
                  replies_due.push_back(runs[m]);
               end
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (replies_due.size() == 0) begin
            $error("reply word with nothing outstanding: data %h ran %b last %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_tdata[1:0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[6:2] !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_tdata[6:2]);
               mismatch_count++;
            end
            if (rsp_tdata[14:7] !== want.run_handle) begin
               $error("run_handle: expected %0d, got %0d", want.run_handle, rsp_tdata[14:7]);
               mismatch_count++;
            end
            if (rsp_tdata[19:15] !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_tdata[19:15]);
               mismatch_count++;
            end
            if (rsp_tuser !== want.ran) begin
               $error("ran: expected %0d, got %0d", want.ran, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // sends one request word, with a random gap first, and predicts its replies
   task automatic send_word(action_type act, logic [7:0] h, logic [15:0] d,
                            logic [15:0] p, logic [3:0] idx);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {4'b0, idx, p, d, h};
      req_tuser  <= act;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_replies(act, h, d, p, idx);
   endtask

   // unused fields carry junk
   task automatic tick_once();
      send_word(ACT_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 4'($urandom_range(15)));
   endtask

   task automatic add_timer(logic [7:0] h, logic [15:0] d, logic [15:0] p);
      send_word(ACT_ADD, h, d, p, 4'($urandom_range(15)));
   endtask

   task automatic delete_at(logic [3:0] idx);
      send_word(ACT_DELETE, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), idx);
   endtask

   task automatic dispatch_due();
      send_word(ACT_DISPATCH, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 4'($urandom_range(15)));
   endtask

   // sender holds off until every reply word has come back
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (replies_due.size() != 0);
   endtask

   function automatic logic [15:0] pick_delay();
      int r;
      r = $urandom_range(9);
      if (r < 6) return 16'($urandom_range(4));
      if (r < 8) return 16'($urandom_range(40));
      return 16'($urandom_range(65535));
   endfunction

   function automatic logic [15:0] pick_period();
      int r;
      r = $urandom_range(9);
      if (r < 4) return '0;
      if (r < 8) return 16'($urandom_range(1, 6));
      return 16'($urandom_range(65535));
   endfunction

   // tick, dispatch and delete on an empty table
   task automatic test_empty_queue();
      tick_once();
      dispatch_due();
      delete_at(4'd0);
   endtask

   // insertion order, field extremes, equal delays, and deletes at a bad and a good position
   task automatic test_add_and_delete();
      add_timer(8'h00, 16'h0000, 16'h0000);
      add_timer(8'hFF, 16'hFFFF, 16'hFFFF);
      add_timer(8'hA5, 16'd5, 16'd3);
      add_timer(8'h5A, 16'd5, 16'd0);
      delete_at(4'd15);
      delete_at(4'd3);
   endtask

   // head counts down, shared delays fall due together, periodic tasks come back
   task automatic test_tick_and_dispatch();
      tick_once();
      dispatch_due();
      repeat (4) tick_once();
      dispatch_due();
   endtask

   // fill the table, one add too many, then deletes at both ends and a dispatch
   task automatic test_full_table();
      while (held < DEPTH) add_timer(8'($urandom_range(255)), pick_delay(), pick_period());
      add_timer(8'h3C, 16'd1, 16'd1);
      delete_at(4'(DEPTH - 1));
      delete_at(4'd0);
      dispatch_due();
   endtask

   // mostly well-formed scheduling traffic with some junk
   task automatic run_random_mix(int items);
      int sent;
      int choice;
      int n;
      sent = 0;
      while (sent < items) begin
         choice = $urandom_range(99);
         if (choice < 28) begin
            n = $urandom_range(1, 3);
            repeat (n) add_timer(8'($urandom_range(255)), pick_delay(), pick_period());
            sent += n;
         end else if (choice < 32) begin
            while (held < DEPTH) begin
               add_timer(8'($urandom_range(255)), pick_delay(), pick_period());
               sent++;
            end
            add_timer(8'($urandom_range(255)), pick_delay(), pick_period());
            sent++;
         end else if (choice < 58) begin
            n = $urandom_range(1, 6);
            repeat (n) tick_once();
            sent += n;
         end else if (choice < 78) begin
            dispatch_due();
            sent++;
         end else if (choice < 90 && held > 0) begin
            delete_at(4'($urandom_range(held - 1)));
            sent++;
         end else begin
            delete_at(4'($urandom_range(15)));
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_mix(30);
      drain_replies();
      send_idle_pct = 77;
      take_idle_pct = 14;
      run_random_mix(30);
      drain_replies();
      send_idle_pct = 0;
      take_idle_pct = 0;
      run_random_mix(30);
   endtask

   // more ticks counted than the far entry has left; it catches up to zero, not wrap
   task automatic test_catchup_clamp();
      while (held > 0) delete_at(4'd0);
      add_timer(8'h11, 16'h0000, 16'h0000);
      add_timer(8'h22, 16'd3, 16'h0000);
      repeat (6) tick_once();
      dispatch_due();
      tick_once();
      dispatch_due();
   endtask

   initial begin
      int i;
      for (i = 0; i < DEPTH; i++) clear_slot(i);
      held        = 0;
      ticks_since = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 14;
      take_idle_pct = 77;
      test_empty_queue();
      test_add_and_delete();
      test_tick_and_dispatch();
      test_full_table();
      test_random_traffic();
      test_catchup_clamp();

      drain_replies();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_task_timer_queue.sv
verif/tb_sorted_task_timer_queue.sv
